// ----- rtl/core/imudfr_pkg.sv -----
package imudfr_pkg;

  // Frame geometry
  localparam int unsigned MAX_FRAME_LEN = 256;
  localparam int unsigned HEAD_LEN      = 6;
  localparam int unsigned CRC_LEN       = 2;
  localparam int unsigned MIN_FRAME_LEN = HEAD_LEN + CRC_LEN;
  localparam int unsigned MAX_PLEN      = MAX_FRAME_LEN - MIN_FRAME_LEN;
  // Payload counter runs up to payload length + 1
  localparam int unsigned CNT_W         = $clog2(MAX_PLEN + 2);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  // Reflected CRC-16
  localparam logic [15:0] CRC_START = 16'h3692;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  // Known messages
  localparam logic [7:0]  CMD_STD     = 8'h00;
  localparam logic [7:0]  ID_DATA1    = 8'h01;
  localparam logic [7:0]  ID_DATA2    = 8'h10;
  localparam logic [7:0]  ID_DATA3    = 8'h13;
  localparam logic [15:0] PLEN_DATA1  = 16'd87;
  localparam logic [15:0] PLEN_DATA2  = 16'd44;
  localparam logic [15:0] PLEN_DATA3  = 16'd105;

  // Result kinds
  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    VD_GOOD,
    VD_CRC,
    VD_UNKNOWN
  } verdict_e;

  typedef enum logic [1:0] {
    MK_NONE,
    MK_DATA1,
    MK_DATA2,
    MK_DATA3
  } msg_kind_e;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_offset;
    verdict_e   frame_verdict;
    msg_kind_e  message_kind;
  } res_t;

  // One byte of reflected CRC, LSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/imudfr_if.sv -----
// Received byte channel
interface imudfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface imudfr_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_offset;
  logic [1:0] frame_verdict;
  logic [1:0] message_kind;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_offset, output frame_verdict, output message_kind,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_offset, input frame_verdict, input message_kind,
                  output ready);
endinterface

// ----- rtl/core/imudfr_parser.sv -----
module imudfr_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [imudfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [imudfr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                               step_i,
  input  logic [7:0]                         byte_i,
  output logic                               res_vld_o,
  output imudfr_pkg::res_t                   res_o
);

  imudfr_pkg::phase_e                  phase_q, phase_d;
  logic [15:0]                         crc_q, crc_d;
  logic [7:0]                          len_lo_q, len_lo_d;
  logic [imudfr_pkg::CNT_W-1:0]        plen_q, plen_d;
  logic [imudfr_pkg::CNT_W-1:0]        seen_q, seen_d;
  logic [7:0]                          cmd_q, cmd_d;
  logic [7:0]                          id_q, id_d;
  logic [7:0]                          crc_lo_q, crc_lo_d;
  logic [7:0]                          sync1_q, sync2_q;

  logic [15:0]                         crc_upd;
  logic [15:0]                         full_len;
  logic                                len_ok;
  imudfr_pkg::msg_kind_e               kind;

  // Shared CRC step: sync1 restarts from the seed
  always_comb begin
    if (phase_q == imudfr_pkg::PH_SYNC1) begin
      crc_upd = imudfr_pkg::crc_byte(imudfr_pkg::CRC_START, byte_i);
    end else begin
      crc_upd = imudfr_pkg::crc_byte(crc_q, byte_i);
    end
  end

  assign full_len = {byte_i, len_lo_q};
  assign len_ok   = (full_len >= 16'(imudfr_pkg::MIN_FRAME_LEN)) &&
                    (full_len <= 16'(imudfr_pkg::MAX_FRAME_LEN));

  // Classify the frame from header and payload length
  always_comb begin
    kind = imudfr_pkg::MK_NONE;
    if (cmd_q == imudfr_pkg::CMD_STD) begin
      if (id_q == imudfr_pkg::ID_DATA1 && 16'(plen_q) == imudfr_pkg::PLEN_DATA1) begin
        kind = imudfr_pkg::MK_DATA1;
      end else if (id_q == imudfr_pkg::ID_DATA2 &&
                   16'(plen_q) == imudfr_pkg::PLEN_DATA2) begin
        kind = imudfr_pkg::MK_DATA2;
      end else if (id_q == imudfr_pkg::ID_DATA3 &&
                   16'(plen_q) == imudfr_pkg::PLEN_DATA3) begin
        kind = imudfr_pkg::MK_DATA3;
      end
    end
  end

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    len_lo_d  = len_lo_q;
    plen_d    = plen_q;
    seen_d    = seen_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    crc_lo_d  = crc_lo_q;
    res_vld_o = 1'b0;
    res_o     = '{result_kind:    imudfr_pkg::RK_PAYLOAD,
                  payload_byte:   8'h00,
                  payload_offset: 8'h00,
                  frame_verdict:  imudfr_pkg::VD_GOOD,
                  message_kind:   imudfr_pkg::MK_NONE};
    if (step_i) begin
      unique case (phase_q)
        imudfr_pkg::PH_SYNC1: begin
          if (byte_i == sync1_q) begin
            crc_d   = crc_upd;
            phase_d = imudfr_pkg::PH_SYNC2;
          end
        end
        imudfr_pkg::PH_SYNC2: begin
          if (byte_i == sync2_q) begin
            crc_d   = crc_upd;
            phase_d = imudfr_pkg::PH_CMD;
          end else begin
            phase_d = imudfr_pkg::PH_SYNC1;
          end
        end
        imudfr_pkg::PH_CMD: begin
          cmd_d   = byte_i;
          crc_d   = crc_upd;
          phase_d = imudfr_pkg::PH_ID;
        end
        imudfr_pkg::PH_ID: begin
          id_d    = byte_i;
          crc_d   = crc_upd;
          phase_d = imudfr_pkg::PH_LEN_LO;
        end
        imudfr_pkg::PH_LEN_LO: begin
          len_lo_d = byte_i;
          crc_d    = crc_upd;
          phase_d  = imudfr_pkg::PH_LEN_HI;
        end
        imudfr_pkg::PH_LEN_HI: begin
          crc_d = crc_upd;
          if (len_ok) begin
            plen_d  = imudfr_pkg::CNT_W'(full_len - 16'(imudfr_pkg::MIN_FRAME_LEN));
            seen_d  = '0;
            phase_d = imudfr_pkg::PH_BODY;
          end else begin
            phase_d = imudfr_pkg::PH_SYNC1;
          end
        end
        imudfr_pkg::PH_BODY: begin
          if (seen_q < plen_q) begin
            // Stream a payload byte
            crc_d                = crc_upd;
            seen_d               = seen_q + 1'b1;
            res_vld_o            = 1'b1;
            res_o.payload_byte   = byte_i;
            res_o.payload_offset = 8'(seen_q);
          end else if (seen_q == plen_q) begin
            crc_lo_d = byte_i;
            seen_d   = seen_q + 1'b1;
          end else begin
            // Second CRC byte: give the verdict
            phase_d           = imudfr_pkg::PH_SYNC1;
            res_vld_o         = 1'b1;
            res_o.result_kind = imudfr_pkg::RK_VERDICT;
            if ({byte_i, crc_lo_q} != crc_q) begin
              res_o.frame_verdict = imudfr_pkg::VD_CRC;
            end else if (kind == imudfr_pkg::MK_NONE) begin
              res_o.frame_verdict = imudfr_pkg::VD_UNKNOWN;
            end else begin
              res_o.message_kind = kind;
            end
          end
        end
        default: begin
          phase_d = imudfr_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= imudfr_pkg::PH_SYNC1;
      crc_q    <= imudfr_pkg::CRC_START;
      len_lo_q <= '0;
      plen_q   <= '0;
      seen_q   <= '0;
      cmd_q    <= '0;
      id_q     <= '0;
      crc_lo_q <= '0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      len_lo_q <= len_lo_d;
      plen_q   <= plen_d;
      seen_q   <= seen_d;
      cmd_q    <= cmd_d;
      id_q     <= id_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // Sync byte registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q <= '0;
      sync2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        imudfr_pkg::CFG_SYNC_FIRST:  sync1_q <= cfg_data_i[7:0];
        imudfr_pkg::CFG_SYNC_SECOND: sync2_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  a_res_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> step_i)
    else $error("result produced without a consumed byte");

  a_verdict_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.result_kind == imudfr_pkg::RK_VERDICT)
      |=> phase_q == imudfr_pkg::PH_SYNC1)
    else $error("parser did not return to hunt after verdict");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == imudfr_pkg::PH_BODY |-> seen_q <= plen_q + 1'b1)
    else $error("payload counter ran past the CRC bytes");

  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == imudfr_pkg::PH_BODY |-> 32'(plen_q) <= imudfr_pkg::MAX_PLEN)
    else $error("payload length beyond maximum frame");

endmodule

// ----- rtl/core/imudfr_out_reg.sv -----
module imudfr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_vld_i,
  input  imudfr_pkg::res_t res_i,
  input  logic             ready_i,
  output logic             space_o,
  output logic             valid_o,
  output imudfr_pkg::res_t res_o
);

  logic             vld_q, vld_d;
  imudfr_pkg::res_t res_q;

  // Free when empty or draining this cycle
  assign space_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i && res_vld_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk_i) begin
    if (load_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/core/imu_frame_deframer_crc16.sv -----
// Serial frame deframer with reflected CRC-16.
// rx_i carries one received byte per transaction; res_o carries one result
// per transaction: a payload byte with its offset, or an end-of-frame verdict
// (good with message kind, CRC mismatch, or unknown command/id/size).
// cfg_we_i/cfg_idx_i/cfg_data_i write the two sync byte values (index 0 and 1)
// and the user must write them only while the block is idle; the block does not enforce it.
// An accepted byte waits in the input register until the output register has
// space; then the parser consumes it and registers any result for res_o.
// Throughput: one byte per cycle while res_o is ready. The input register, the
// parser logic and the output register form a two-stage path; the CRC step
// and phase decode are combinational logic.
// Reset: the parser hunts for the first sync byte, the CRC seed is loaded and
// both sync values are zero.
// Stall: when res_o is not ready, the held result stays; one more byte is
// taken into the input register and then rx_i.ready falls until res_o drains.
module imu_frame_deframer_crc16 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [imudfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [imudfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  imudfr_rx_if.sink                         rx_i,
  imudfr_res_if.source                      res_o
);

  logic             rx_vld_q;
  logic [7:0]       rx_byte_q;
  logic             space;
  logic             step;
  logic             res_vld;
  imudfr_pkg::res_t res;
  imudfr_pkg::res_t out_res;
  logic             out_vld;

  // Consume the held byte when the output register can take its result
  assign step     = rx_vld_q && space;
  assign rx_i.ready = !rx_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      rx_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      rx_byte_q <= rx_i.rx_byte;
    end
  end

  imudfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .byte_i     (rx_byte_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  imudfr_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .res_vld_i (res_vld),
    .res_i     (res),
    .ready_i   (res_o.ready),
    .space_o   (space),
    .valid_o   (out_vld),
    .res_o     (out_res)
  );

  // Drive the result channel
  assign res_o.valid          = out_vld;
  assign res_o.result_kind    = out_res.result_kind;
  assign res_o.payload_byte   = out_res.payload_byte;
  assign res_o.payload_offset = out_res.payload_offset;
  assign res_o.frame_verdict  = out_res.frame_verdict;
  assign res_o.message_kind   = out_res.message_kind;

endmodule

// ----- tb/deframe_tb_pkg.sv -----
`timescale 1ns / 100ps
package deframe_tb_pkg;

  import imudfr_pkg::CRC_POLY;

  // Advance the reflected CRC by one byte, feeding one data bit per shift
  function automatic logic [15:0] crc_next(logic [15:0] acc, logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ----- tb/deframe_checker.sv -----
`timescale 1ns / 100ps
module deframe_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [imudfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [imudfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  imudfr_rx_if                              rx_mon,
  imudfr_res_if                             res_mon,
  output int                                bad_result_count_o,
  output int                                pending_o,
  output int                                payload_count_o,
  output int                                good_count_o,
  output int                                crc_err_count_o,
  output int                                unknown_count_o
);

  import imudfr_pkg::*;
  import deframe_tb_pkg::*;

  // Shadow of the parser state and sync registers
  phase_e      phase;
  logic [15:0] crc_acc;
  logic [15:0] frame_len;
  logic [15:0] body_cnt;
  logic [7:0]  cmd_q;
  logic [7:0]  id_q;
  logic [7:0]  crc_lo_q;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;

  // Results still owed by the block, oldest first
  res_t deframed_q[$];
  res_t seen_r;
  res_t owed_r;

  // Advance the shadow parser by one received byte, queue any result
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] plen;
    logic [15:0] rx_crc;
    res_t        r;
    r = '0;
    case (phase)
      PH_SYNC1: begin
        if (b == sync_a) begin
          crc_acc = crc_next(CRC_START, b);
          phase   = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // a mismatching byte is dropped, not retried as first sync
        if (b == sync_b) begin
          crc_acc = crc_next(crc_acc, b);
          phase   = PH_CMD;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_CMD: begin
        cmd_q   = b;
        crc_acc = crc_next(crc_acc, b);
        phase   = PH_ID;
      end
      PH_ID: begin
        id_q    = b;
        crc_acc = crc_next(crc_acc, b);
        phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {8'h00, b};
        crc_acc   = crc_next(crc_acc, b);
        phase     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len[15:8] = b;
        crc_acc         = crc_next(crc_acc, b);
        // out-of-range length drops back to the hunt silently
        if (frame_len >= MIN_FRAME_LEN && frame_len <= MAX_FRAME_LEN) begin
          body_cnt = '0;
          phase    = PH_BODY;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_BODY: begin
        plen = frame_len - 16'(MIN_FRAME_LEN);
        if (body_cnt < plen) begin
          crc_acc          = crc_next(crc_acc, b);
          r.result_kind    = RK_PAYLOAD;
          r.payload_byte   = b;
          r.payload_offset = body_cnt[7:0];
          deframed_q.push_back(r);
          body_cnt++;
        end else if (body_cnt == plen) begin
          crc_lo_q = b;
          body_cnt++;
        end else begin
          rx_crc          = {b, crc_lo_q};
          phase           = PH_SYNC1;
          r.result_kind   = RK_VERDICT;
          r.frame_verdict = VD_UNKNOWN;
          r.message_kind  = MK_NONE;
          if (rx_crc != crc_acc) begin
            r.frame_verdict = VD_CRC;
          end else if (cmd_q == CMD_STD) begin
            if (id_q == ID_DATA1 && plen == PLEN_DATA1) begin
              r.message_kind = MK_DATA1;
            end else if (id_q == ID_DATA2 && plen == PLEN_DATA2) begin
              r.message_kind = MK_DATA2;
            end else if (id_q == ID_DATA3 && plen == PLEN_DATA3) begin
              r.message_kind = MK_DATA3;
            end
            if (r.message_kind != MK_NONE) begin
              r.frame_verdict = VD_GOOD;
            end
          end
          deframed_q.push_back(r);
        end
      end
      default: begin
        phase = PH_SYNC1;
      end
    endcase
  endtask

  // Track register writes, compare results, then predict from new bytes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase              = PH_SYNC1;
      crc_acc            = CRC_START;
      frame_len          = '0;
      body_cnt           = '0;
      cmd_q              = '0;
      id_q               = '0;
      crc_lo_q           = '0;
      sync_a             = '0;
      sync_b             = '0;
      deframed_q.delete();
      bad_result_count_o = 0;
      pending_o          = 0;
      payload_count_o    = 0;
      good_count_o       = 0;
      crc_err_count_o    = 0;
      unknown_count_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_a = cfg_data_i;
          CFG_SYNC_SECOND: sync_b = cfg_data_i;
          default: ;
        endcase
      end

      if (res_mon.valid && res_mon.ready) begin
        seen_r.result_kind    = res_mon.result_kind;
        seen_r.payload_byte   = res_mon.payload_byte;
        seen_r.payload_offset = res_mon.payload_offset;
        seen_r.frame_verdict  = verdict_e'(res_mon.frame_verdict);
        seen_r.message_kind   = msg_kind_e'(res_mon.message_kind);
        if (deframed_q.size() == 0) begin
          bad_result_count_o++;
          if (bad_result_count_o <= 10) begin
            $display("%0t: unexpected result kind %0d byte %0h offset %0d verdict %0d msg %0d",
                     $time, seen_r.result_kind, seen_r.payload_byte, seen_r.payload_offset,
                     seen_r.frame_verdict, seen_r.message_kind);
          end
        end else begin
          owed_r = deframed_q.pop_front();
          if (seen_r.result_kind !== owed_r.result_kind ||
              seen_r.payload_byte !== owed_r.payload_byte ||
              seen_r.payload_offset !== owed_r.payload_offset ||
              seen_r.frame_verdict !== owed_r.frame_verdict ||
              seen_r.message_kind !== owed_r.message_kind) begin
            bad_result_count_o++;
            if (bad_result_count_o <= 10) begin
              $display("%0t: result mismatch: expected kind %0d byte %0h offset %0d verdict %0d msg %0d",
                       $time, owed_r.result_kind, owed_r.payload_byte, owed_r.payload_offset,
                       owed_r.frame_verdict, owed_r.message_kind);
              $display("%0t:                  got      kind %0d byte %0h offset %0d verdict %0d msg %0d",
                       $time, seen_r.result_kind, seen_r.payload_byte, seen_r.payload_offset,
                       seen_r.frame_verdict, seen_r.message_kind);
            end
          end else if (owed_r.result_kind == RK_PAYLOAD) begin
            payload_count_o++;
          end else begin
            case (owed_r.frame_verdict)
              VD_GOOD: good_count_o++;
              VD_CRC:  crc_err_count_o++;
              default: unknown_count_o++;
            endcase
          end
        end
      end

      if (rx_mon.valid && rx_mon.ready) begin
        deframe_byte(rx_mon.rx_byte);
      end
      pending_o = deframed_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

  import imudfr_pkg::*;
  import deframe_tb_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = 4;
  localparam int STALL_CYCLES  = 64;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_BYTES   = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  imudfr_rx_if  rx_if ();
  imudfr_res_if res_if ();

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          long_stall;
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  int          bytes_sent;
  int          frames_sent;
  int          quiet_cycles;

  int bad_result_count;
  int pending;
  int payload_count;
  int good_count;
  int crc_err_count;
  int unknown_count;

  always #HALF_PERIOD clk_i = ~clk_i;

  imu_frame_deframer_crc16 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  deframe_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .rx_mon             (rx_if),
    .res_mon            (res_if),
    .bad_result_count_o (bad_result_count),
    .pending_o          (pending),
    .payload_count_o    (payload_count),
    .good_count_o       (good_count),
    .crc_err_count_o    (crc_err_count),
    .unknown_count_o    (unknown_count)
  );

  // Offer one byte after a random gap, hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) begin
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  // Send a frame with random payload; an out-of-range length stops after the header
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] id,
                            input logic [15:0] total_len, input bit bad_crc);
    logic [15:0] acc;
    logic [7:0]  hdr [6];
    logic [7:0]  b;
    int          plen;
    hdr = '{sync_a, sync_b, cmd, id, total_len[7:0], total_len[15:8]};
    acc = CRC_START;
    for (int i = 0; i < 6; i++) begin
      acc = crc_next(acc, hdr[i]);
      send_byte(hdr[i]);
    end
    if (total_len < MIN_FRAME_LEN || total_len > MAX_FRAME_LEN) begin
      return;
    end
    plen = int'(total_len) - int'(MIN_FRAME_LEN);
    for (int i = 0; i < plen; i++) begin
      b   = 8'($urandom);
      acc = crc_next(acc, b);
      send_byte(b);
    end
    if (bad_crc) begin
      acc = acc ^ (16'h0001 << $urandom_range(15));
    end
    send_byte(acc[7:0]);
    send_byte(acc[15:8]);
    frames_sent++;
  endtask

  // Frame of one of the three known message kinds, length optionally skewed
  task automatic send_known_frame(input int kind, input logic [7:0] cmd,
                                  input int len_skew, input bit bad_crc);
    logic [7:0]  id;
    logic [15:0] plen;
    case (kind)
      0:       begin id = ID_DATA1; plen = PLEN_DATA1; end
      1:       begin id = ID_DATA2; plen = PLEN_DATA2; end
      default: begin id = ID_DATA3; plen = PLEN_DATA3; end
    endcase
    send_frame(cmd, id, 16'(int'(plen) + int'(MIN_FRAME_LEN) + len_skew), bad_crc);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic send_random_traffic(input int stop_at);
    int          pick;
    logic [7:0]  b;
    logic [7:0]  id;
    logic [7:0]  cmd;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      cmd  = $urandom_range(1) ? CMD_STD : 8'($urandom);
      if (pick < 25) begin
        send_known_frame($urandom_range(2), ($urandom_range(9) == 0) ? 8'($urandom) : CMD_STD,
                         ($urandom_range(7) == 0) ? ($urandom_range(1) ? 1 : -1) : 0,
                         $urandom_range(9) == 0);
      end else if (pick < 60) begin
        case ($urandom_range(4))
          0:       id = ID_DATA1;
          1:       id = ID_DATA2;
          2:       id = ID_DATA3;
          default: id = 8'($urandom);
        endcase
        send_frame(cmd, id, 16'(MIN_FRAME_LEN + $urandom_range(20)), $urandom_range(3) == 0);
      end else if (pick < 72) begin
        send_frame(cmd, 8'($urandom),
                   $urandom_range(1) ? 16'($urandom_range(MIN_FRAME_LEN - 1))
                                     : 16'($urandom_range(65535, MAX_FRAME_LEN + 1)),
                   1'b0);
      end else if (pick < 86) begin
        // first sync followed by a wrong second sync
        b = $urandom_range(1) ? sync_a : 8'($urandom);
        while (b == sync_b) begin
          b = 8'($urandom);
        end
        send_byte(sync_a);
        send_byte(b);
      end else begin
        // noise that never starts a frame
        repeat ($urandom_range(8, 1)) begin
          b = 8'($urandom);
          while (b == sync_a) begin
            b = 8'($urandom);
          end
          send_byte(b);
        end
      end
    end
  endtask

  // Let the block empty out before touching its registers or ending
  task automatic drain_block();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SYNC_FIRST;
    cfg_data <= first;
    @(posedge clk_i);
    cfg_idx  <= CFG_SYNC_SECOND;
    cfg_data <= second;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sync_a = first;
    sync_b = second;
  endtask

  // Result side: random back-pressure, or a long hold-off when requested
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        res_if.ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk_i);
        long_stall = 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d results outstanding", quiet_cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SYNC_FIRST;
    cfg_data      = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    tx_idle_pct   = 35;
    rx_idle_pct   = 55;
    long_stall    = 1'b0;
    sync_a        = '0;
    sync_b        = '0;
    bytes_sent    = 0;
    frames_sent   = 0;
    quiet_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty frame with reset sync values, id without matching size
    send_frame(CMD_STD, ID_DATA1, 16'(MIN_FRAME_LEN), 1'b0);
    drain_block();
    write_sync(8'hAA, 8'h55);
    // second sync mismatch where the bad byte equals the first sync
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h55);
    // length just below minimum and just above maximum
    send_frame(8'hFF, 8'hFF, 16'(MIN_FRAME_LEN - 1), 1'b0);
    send_frame(CMD_STD, ID_DATA2, 16'(MAX_FRAME_LEN + 1), 1'b0);
    // empty frame with a corrupted CRC
    send_frame(8'hFF, 8'h00, 16'(MIN_FRAME_LEN), 1'b1);

    // Sender idles 35 %, receiver 55 %; one good frame of each kind first
    for (int k = 0; k < 3; k++) begin
      send_known_frame(k, CMD_STD, 0, 1'b0);
    end
    send_random_traffic(bytes_sent + PHASE_BYTES);
    drain_block();

    // Swap idling, equal all-ones sync bytes
    write_sync(8'hFF, 8'hFF);
    tx_idle_pct = 55;
    rx_idle_pct = 35;
    send_random_traffic(bytes_sent + PHASE_BYTES);
    drain_block();

    // No idling, random sync; fill the block under a long hold-off first
    write_sync(8'($urandom), 8'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_stall  = 1'b1;
    send_frame(CMD_STD, 8'($urandom), 16'(MAX_FRAME_LEN), 1'b0);
    send_random_traffic(bytes_sent + PHASE_BYTES);
    drain_block();

    $display("Sent %0d bytes in %0d complete frames under four sync settings",
             bytes_sent, frames_sent);
    $display("and three idling mixes; checked %0d payload bytes, verdicts: %0d good, %0d CRC error, %0d unknown",
             payload_count, good_count, crc_err_count, unknown_count);
    if (bad_result_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
